// ----- src/fgs_pkg.sv -----
// Package for the accelerometer FIR / gyro scale block: constants, types and coefficients.
`default_nettype none

package fgs_pkg;

    localparam int TAPS       = 19;
    localparam int HIST_DEPTH = TAPS - 1;
    localparam int PAIRS      = (TAPS - 1) / 2;
    localparam int AXES       = 3;

    localparam int SMP_W   = 16;
    localparam int FIR_W   = 17;
    localparam int RATE_W  = 24;
    localparam int SCALE_W = 16;

    localparam int DIG_BITS = 4;
    localparam int OPND_W   = 20;
    localparam int NDIG     = OPND_W / DIG_BITS;
    localparam int MULT_W   = 17;
    localparam int PROD_W   = MULT_W + DIG_BITS + 1;
    localparam int ACC_W    = 34;

    localparam int FIR_FRAC  = 15;
    localparam int RATE_FRAC = 8;

    localparam logic [SCALE_W-1:0] GYRO_SCALE_RESET = 16'd17855;

    typedef logic [3:0] term_t;
    typedef logic [2:0] dig_t;

    localparam term_t CENTER_TERM = term_t'(PAIRS);
    localparam term_t GYRO_TERM   = term_t'(PAIRS + 1);
    localparam dig_t  DIG_LAST    = dig_t'(NDIG - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } fgs_state_t;

    typedef struct packed {
        logic en;
        logic clear;
        logic fir_cap;
        dig_t dig;
    } fgs_lane_ctl_t;

    // Q15 coefficients, first half plus center; h[k] = h[18-k]
    function automatic logic signed [MULT_W-1:0] coef(input term_t k);
        logic signed [MULT_W-1:0] c;
        case (k)
            4'd0:    c = -17'sd157;
            4'd1:    c = 17'sd0;
            4'd2:    c = 17'sd508;
            4'd3:    c = 17'sd609;
            4'd4:    c = -17'sd498;
            4'd5:    c = -17'sd1943;
            4'd6:    c = -17'sd1130;
            4'd7:    c = 17'sd3424;
            4'd8:    c = 17'sd9440;
            4'd9:    c = 17'sd12252;
            default: c = 17'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/fgs_if.sv -----
// Valid/ready channel interfaces for the IMU sample and the filtered result.
`default_nettype none

interface fgs_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    output ready);
endinterface

interface fgs_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] filt_accel_x;
    logic signed [16:0] filt_accel_y;
    logic signed [16:0] filt_accel_z;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;

    modport source (output valid, filt_accel_x, filt_accel_y, filt_accel_z,
                    rate_x, rate_y, rate_z, input ready);
    modport sink   (input valid, filt_accel_x, filt_accel_y, filt_accel_z,
                    rate_x, rate_y, rate_z, output ready);
endinterface

`default_nettype wire

// ----- src/fgs_lane.sv -----
// Digit-serial multiply-accumulate lane: FIR sum and gyro product for one axis.
`default_nettype none

module fgs_lane
    import fgs_pkg::*;
(
    input  wire logic                      clk,
    input  wire fgs_lane_ctl_t             ctl,
    input  wire logic signed [MULT_W-1:0]  mult,
    input  wire logic        [OPND_W-1:0]  opnd,
    output logic signed      [FIR_W-1:0]   fir,
    output logic signed      [RATE_W-1:0]  rate
);

    logic [OPND_W-DIG_BITS-1:0] sreg_reg, sreg_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [FIR_W-1:0]           fir_reg, fir_next;

    logic [DIG_BITS-1:0]      dig_bits;
    logic signed [DIG_BITS:0] dig_s;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]         prod_ext;
    logic [ACC_W-1:0]         addend;
    logic [ACC_W-1:0]         rnd;

    always_comb
    begin
        dig_bits = (ctl.dig == '0) ? opnd[DIG_BITS-1:0] : sreg_reg[DIG_BITS-1:0];
        // top digit carries the sign
        dig_s    = (ctl.dig == DIG_LAST) ? {dig_bits[DIG_BITS-1], dig_bits}
                                         : {1'b0, dig_bits};
        prod     = mult * dig_s;
        prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        case (ctl.dig)
            3'd0:    addend = prod_ext;
            3'd1:    addend = prod_ext << DIG_BITS;
            3'd2:    addend = prod_ext << (2 * DIG_BITS);
            3'd3:    addend = prod_ext << (3 * DIG_BITS);
            3'd4:    addend = prod_ext << (4 * DIG_BITS);
            default: addend = '0;
        endcase
        rnd = acc_reg + (ACC_W'(1) << (FIR_FRAC - 1));

        sreg_next = sreg_reg;
        acc_next  = acc_reg;
        fir_next  = fir_reg;
        if (ctl.en)
        begin
            sreg_next = (ctl.dig == '0) ? opnd[OPND_W-1:DIG_BITS]
                                        : {{DIG_BITS{1'b0}}, sreg_reg[OPND_W-DIG_BITS-1:DIG_BITS]};
            acc_next  = (ctl.clear ? '0 : acc_reg) + addend;
            if (ctl.fir_cap)
            begin
                fir_next = rnd[FIR_FRAC+FIR_W-1:FIR_FRAC];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sreg_reg <= sreg_next;
        acc_reg  <= acc_next;
        fir_reg  <= fir_next;
    end

    assign fir  = fir_reg;
    assign rate = acc_reg[RATE_FRAC+RATE_W-1:RATE_FRAC];

endmodule

`default_nettype wire

// ----- src/accel_fir_gyro_scale_top.sv -----
// Top level: 19-tap symmetric FIR on three accelerometer axes, gyro scaling on three axes.
//
//  channel     dir   handshake        payload
//  sample_ch   sink  valid/ready      accel_x/y/z, gyro_x/y/z (16b signed)
//  result_ch   src   valid/ready      filt_accel_x/y/z (17b), rate_x/y/z (24b)
//  cfg         sink  cfg_wr_en        cfg_wr_data -> gyro_scale (16b, unsigned Q8.8)
//
// Each transaction is an accept, MAC steps over 11 terms of 5 four-bit digits
// (through each axis lane's serial multiplier), and a writeback.
// One transaction in flight; the next is taken once the writeback is done.
// Writeback waits while the result register still holds an untaken result.
// Reset clears the sample history and sets gyro_scale to 17855.
`default_nettype none

module accel_fir_gyro_scale_top
    import fgs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    fgs_sample_if.sink              sample_ch,
    fgs_result_if.source            result_ch,
    input  wire logic               cfg_wr_en,
    input  wire logic [SCALE_W-1:0] cfg_wr_data
);

    fgs_state_t state_reg, state_next;
    term_t      term_reg, term_next;
    dig_t       dig_reg, dig_next;

    logic [SCALE_W-1:0] scale_reg;

    logic [SMP_W-1:0] cur_reg  [AXES];
    logic [SMP_W-1:0] hist_reg [AXES][HIST_DEPTH];
    logic [SMP_W-1:0] gyro_reg [AXES];

    logic                    res_valid_reg, res_valid_next;
    logic signed [FIR_W-1:0]  filt_reg [AXES];
    logic signed [RATE_W-1:0] rate_reg [AXES];

    logic accept, rotate, wb;
    fgs_lane_ctl_t             lane_ctl;
    logic signed [MULT_W-1:0]  mult;
    logic        [OPND_W-1:0]  opnd     [AXES];
    logic signed [FIR_W-1:0]   lane_fir [AXES];
    logic signed [RATE_W-1:0]  lane_rate[AXES];
    logic        [SMP_W:0]     pair_sum [AXES];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (sample_ch.valid)
                begin
                    state_next = ST_RUN;
                end
            ST_RUN:
                if (term_reg == GYRO_TERM && dig_reg == DIG_LAST)
                begin
                    state_next = ST_DONE;
                end
            ST_DONE:
                if (!res_valid_reg || result_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        sample_ch.ready  = (state_reg == ST_IDLE);
        accept           = sample_ch.valid && (state_reg == ST_IDLE);
        wb               = (state_reg == ST_DONE) && (!res_valid_reg || result_ch.ready);
        rotate           = (state_reg == ST_RUN) && (dig_reg == DIG_LAST)
                           && (term_reg < CENTER_TERM);
        lane_ctl.en      = (state_reg == ST_RUN);
        lane_ctl.dig     = dig_reg;
        lane_ctl.clear   = (dig_reg == '0) && (term_reg == '0 || term_reg == GYRO_TERM);
        lane_ctl.fir_cap = (dig_reg == '0) && (term_reg == GYRO_TERM);
    end

    // term and digit counters
    always_comb
    begin
        term_next = term_reg;
        dig_next  = dig_reg;
        if (accept)
        begin
            term_next = '0;
            dig_next  = '0;
        end
        else if (state_reg == ST_RUN)
        begin
            if (dig_reg == DIG_LAST)
            begin
                dig_next  = '0;
                term_next = term_reg + term_t'(1);
            end
            else
            begin
                dig_next = dig_reg + dig_t'(1);
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (wb)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            term_reg      <= '0;
            dig_reg       <= '0;
            res_valid_reg <= 1'b0;
            scale_reg     <= GYRO_SCALE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            dig_reg       <= dig_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
        end
    end

    // Tap window: front ring {cur, hist[0..7]} and back ring {hist[17..9]}
    // rotate together so the ends always present taps k and 18-k.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                cur_reg[a] <= '0;
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    hist_reg[a][i] <= '0;
                end
            end
        end
        else if (accept)
        begin
            cur_reg[0] <= sample_ch.accel_x;
            cur_reg[1] <= sample_ch.accel_y;
            cur_reg[2] <= sample_ch.accel_z;
        end
        else if (rotate)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                cur_reg[a]              <= hist_reg[a][0];
                for (int i = 0; i < PAIRS - 2; i++)
                begin
                    hist_reg[a][i] <= hist_reg[a][i+1];
                end
                hist_reg[a][PAIRS-2]    <= cur_reg[a];
                for (int i = PAIRS + 1; i < HIST_DEPTH; i++)
                begin
                    hist_reg[a][i] <= hist_reg[a][i-1];
                end
                hist_reg[a][PAIRS]      <= hist_reg[a][HIST_DEPTH-1];
            end
        end
        else if (wb)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                hist_reg[a][0] <= cur_reg[a];
                for (int i = 1; i < HIST_DEPTH; i++)
                begin
                    hist_reg[a][i] <= hist_reg[a][i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gyro_reg[0] <= sample_ch.gyro_x;
            gyro_reg[1] <= sample_ch.gyro_y;
            gyro_reg[2] <= sample_ch.gyro_z;
        end
        if (wb)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                filt_reg[a] <= lane_fir[a];
                rate_reg[a] <= lane_rate[a];
            end
        end
    end

    always_comb
    begin
        mult = (term_reg == GYRO_TERM) ? {1'b0, scale_reg} : coef(term_reg);
        for (int a = 0; a < AXES; a++)
        begin
            pair_sum[a] = {cur_reg[a][SMP_W-1], cur_reg[a]}
                        + {hist_reg[a][HIST_DEPTH-1][SMP_W-1], hist_reg[a][HIST_DEPTH-1]};
            if (term_reg == GYRO_TERM)
            begin
                opnd[a] = {{(OPND_W-SMP_W){gyro_reg[a][SMP_W-1]}}, gyro_reg[a]};
            end
            else if (term_reg == CENTER_TERM)
            begin
                opnd[a] = {{(OPND_W-SMP_W){hist_reg[a][PAIRS-1][SMP_W-1]}},
                           hist_reg[a][PAIRS-1]};
            end
            else
            begin
                opnd[a] = {{(OPND_W-SMP_W-1){pair_sum[a][SMP_W]}}, pair_sum[a]};
            end
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        fgs_lane u_lane (
            .clk  (clk),
            .ctl  (lane_ctl),
            .mult (mult),
            .opnd (opnd[a]),
            .fir  (lane_fir[a]),
            .rate (lane_rate[a])
        );
    end

    assign result_ch.valid        = res_valid_reg;
    assign result_ch.filt_accel_x = filt_reg[0];
    assign result_ch.filt_accel_y = filt_reg[1];
    assign result_ch.filt_accel_z = filt_reg[2];
    assign result_ch.rate_x       = rate_reg[0];
    assign result_ch.rate_y       = rate_reg[1];
    assign result_ch.rate_z       = rate_reg[2];

endmodule

`default_nettype wire

// ----- src/fgs_checker.sv -----
// Port-level checker for the accelerometer FIR / gyro scale top level, with its bind.
`default_nettype none

module fgs_checker
    import fgs_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     r_valid,
    input wire logic                     r_ready,
    input wire logic signed [FIR_W-1:0]  r_fir,
    input wire logic signed [RATE_W-1:0] r_rate
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result valid dropped before transaction");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> $stable(r_fir) && $stable(r_rate))
        else $error("result payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |-> ##1 !s_ready ##1 !s_ready)
        else $error("sample taken while a transaction is in progress");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(r_valid) |-> !$past(s_ready))
        else $error("result appeared without a finished computation");

endmodule

bind accel_fir_gyro_scale_top fgs_checker u_fgs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample_ch.valid),
    .s_ready (sample_ch.ready),
    .r_valid (result_ch.valid),
    .r_ready (result_ch.ready),
    .r_fir   (result_ch.filt_accel_x),
    .r_rate  (result_ch.rate_x)
);

`default_nettype wire
